### hdl/multi_channel_blink_timer_defines.svh
// Assertion macros used by the blink timer checker.
// Depends on nothing; include by bare file name.
`ifndef MULTI_CHANNEL_BLINK_TIMER_DEFINES_SVH
`define MULTI_CHANNEL_BLINK_TIMER_DEFINES_SVH

// Generic clocked assertion with explicit clock and active-low reset.
`define MCBT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Shorthand for the block's own clock and reset names.
`define MCBT_ASSERT(lbl, prop, msg) \
  `MCBT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### hdl/mcbt_pkg.sv
// Package for the multi-channel blink timer: sizes, opcodes, channel command
// struct and the period clamp function. Depends on nothing.
`default_nettype none

package mcbt_pkg;

  localparam int CHANNELS        = 8;
  localparam int TICK_WIDTH      = 16;
  localparam int REPEAT_WIDTH    = 16;
  localparam int PERIOD_IN_WIDTH = 16;
  localparam int CHAN_WIDTH      = 3;
  localparam int MASK_WIDTH      = 8;

  typedef logic [TICK_WIDTH-1:0] tick_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_e;

  // Command presented to every channel in the update cycle
  typedef struct packed {
    logic                    load;
    logic                    tick;
    logic [REPEAT_WIDTH-1:0] repeat_count;
    tick_t                   period_one;
    tick_t                   period_two;
  } ch_cmd_t;

  // Truncate to the counter width; zero means one tick
  function automatic tick_t fix_period(logic [PERIOD_IN_WIDTH-1:0] p);
    logic [63:0] wide;
    tick_t       v;
    wide = 64'(p);
    v    = wide[TICK_WIDTH-1:0];
    if (v == '0) begin
      v = tick_t'(1);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### hdl/mcbt_channel.sv
// One blink channel: period counter, phase, toggle count and run flag.
// Depends on mcbt_pkg.
`default_nettype none

module mcbt_channel (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mcbt_pkg::ch_cmd_t cmd_i,
  output logic                  toggle_o,
  output logic                  active_o
);

  logic                              active_q, active_d;
  logic                              endless_q, endless_d;
  logic                              first_q, first_d;
  mcbt_pkg::tick_t                   ticks_q, ticks_d;
  mcbt_pkg::tick_t                   per1_q, per1_d;
  mcbt_pkg::tick_t                   per2_q, per2_d;
  logic [mcbt_pkg::REPEAT_WIDTH-1:0] togs_q, togs_d;
  logic [mcbt_pkg::REPEAT_WIDTH-1:0] togs_dec;
  logic                              expire;

  assign togs_dec = togs_q - mcbt_pkg::REPEAT_WIDTH'(1);
  assign expire   = cmd_i.tick && active_q &&
                    (ticks_q <= mcbt_pkg::tick_t'(1));

  always_comb begin
    active_d  = active_q;
    endless_d = endless_q;
    first_d   = first_q;
    ticks_d   = ticks_q;
    per1_d    = per1_q;
    per2_d    = per2_q;
    togs_d    = togs_q;
    if (cmd_i.load) begin
      togs_d    = cmd_i.repeat_count;
      endless_d = (cmd_i.repeat_count == '0);
      per1_d    = cmd_i.period_one;
      per2_d    = cmd_i.period_two;
      first_d   = 1'b1;
      active_d  = 1'b1;
      ticks_d   = cmd_i.period_one;
    end else if (expire) begin
      first_d = !first_q;
      ticks_d = first_q ? per2_q : per1_q;
      if (!endless_q) begin
        togs_d = togs_dec;
        if (togs_dec == '0) begin
          active_d = 1'b0;
        end
      end
    end else if (cmd_i.tick && active_q) begin
      ticks_d = ticks_q - mcbt_pkg::tick_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      endless_q <= 1'b0;
      first_q   <= 1'b0;
      ticks_q   <= '0;
      per1_q    <= '0;
      per2_q    <= '0;
      togs_q    <= '0;
    end else begin
      active_q  <= active_d;
      endless_q <= endless_d;
      first_q   <= first_d;
      ticks_q   <= ticks_d;
      per1_q    <= per1_d;
      per2_q    <= per2_d;
      togs_q    <= togs_d;
    end
  end

  assign toggle_o = expire;
  assign active_o = active_q;

endmodule

`default_nettype wire

### hdl/multi_channel_blink_timer.sv
// Multi-channel blink timer top level: request register, channel bank and
// result register. Depends on mcbt_pkg and mcbt_channel.
//
//   channel  direction  ports                                   handshake
//   request  in         operation/channel/repeat_count/         start_i, busy_o
//                       first_period/second_period
//   result   out        toggle_mask_o, active_mask_o            valid_o strobe
//
// A request is taken at any edge with start_i high; busy_o is held low, so one
// request per cycle is sustained. Its result strobes valid_o from the result
// register, after the request register and the channel update logic.
// Reset is asynchronous, active low, and stops every channel.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module multi_channel_blink_timer (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic                                 operation_i,
  input  wire logic [mcbt_pkg::CHAN_WIDTH-1:0]      channel_i,
  input  wire logic [mcbt_pkg::REPEAT_WIDTH-1:0]    repeat_count_i,
  input  wire logic [mcbt_pkg::PERIOD_IN_WIDTH-1:0] first_period_i,
  input  wire logic [mcbt_pkg::PERIOD_IN_WIDTH-1:0] second_period_i,
  output logic                                      valid_o,
  output logic [mcbt_pkg::MASK_WIDTH-1:0]           toggle_mask_o,
  output logic [mcbt_pkg::MASK_WIDTH-1:0]           active_mask_o
);

  // ---- request register ----
  logic                              req_valid_q;
  logic                              req_start_q;
  logic [mcbt_pkg::CHAN_WIDTH-1:0]   req_chan_q;
  logic [mcbt_pkg::REPEAT_WIDTH-1:0] req_repeat_q;
  mcbt_pkg::tick_t                   req_per1_q;
  mcbt_pkg::tick_t                   req_per2_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start_i;
    end
  end

  // payload: periods are clamped on the way in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      req_start_q  <= (operation_i == mcbt_pkg::OP_START);
      req_chan_q   <= channel_i;
      req_repeat_q <= repeat_count_i;
      req_per1_q   <= mcbt_pkg::fix_period(first_period_i);
      req_per2_q   <= mcbt_pkg::fix_period(second_period_i);
    end
  end

  // ---- channel bank ----
  logic [mcbt_pkg::CHANNELS-1:0] toggle_vec;
  logic [mcbt_pkg::CHANNELS-1:0] active_vec;

  for (genvar c = 0; c < mcbt_pkg::CHANNELS; c++) begin : g_chan
    mcbt_pkg::ch_cmd_t cmd;

    // A start names one channel; the 3-bit field reaches all eight channels.
    assign cmd.load         = req_valid_q && req_start_q &&
                              (32'(req_chan_q) == c);
    assign cmd.tick         = req_valid_q && !req_start_q;
    assign cmd.repeat_count = req_repeat_q;
    assign cmd.period_one   = req_per1_q;
    assign cmd.period_two   = req_per2_q;

    mcbt_channel u_chan (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .toggle_o (toggle_vec[c]),
      .active_o (active_vec[c])
    );
  end

  // ---- result register ----
  // Channel state updates on the same edge, so active_vec already reflects
  // this request when valid_o is up.
  logic                            res_valid_q;
  logic [mcbt_pkg::MASK_WIDTH-1:0] toggle_d;
  logic [mcbt_pkg::MASK_WIDTH-1:0] toggle_q;
  logic [mcbt_pkg::MASK_WIDTH-1:0] active_mask;

  // every channel has a bit in the masks; bits beyond CHANNELS read zero
  for (genvar b = 0; b < mcbt_pkg::MASK_WIDTH; b++) begin : g_mask
    if (b < mcbt_pkg::CHANNELS) begin : g_on
      assign toggle_d[b]    = toggle_vec[b];
      assign active_mask[b] = active_vec[b];
    end else begin : g_off
      assign toggle_d[b]    = 1'b0;
      assign active_mask[b] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      toggle_q <= toggle_d;
    end
  end

  assign valid_o       = res_valid_q;
  assign toggle_mask_o = toggle_q;
  assign active_mask_o = active_mask;

endmodule

`default_nettype wire

### hdl/mcbt_checker.sv
// Port-level checker for the multi-channel blink timer, with its bind.
// Depends on mcbt_pkg and multi_channel_blink_timer_defines.svh.
`default_nettype none

`include "multi_channel_blink_timer_defines.svh"

module mcbt_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            start_i,
  input wire logic                            busy_o,
  input wire logic                            operation_i,
  input wire logic                            valid_o,
  input wire logic [mcbt_pkg::MASK_WIDTH-1:0] toggle_mask_o,
  input wire logic [mcbt_pkg::MASK_WIDTH-1:0] active_mask_o
);

  // every request gets its result strobe on valid_o
  `MCBT_ASSERT(a_req_to_res, start_i && !busy_o |-> ##2 valid_o, "request lost")

  // no result without a request
  `MCBT_ASSERT(a_res_from_req, valid_o |-> $past(start_i && !busy_o, 2), "result invented")

  // only a channel that was running can toggle
  `MCBT_ASSERT(a_toggle_active, valid_o |-> ((toggle_mask_o & ~$past(active_mask_o)) == '0), "toggle on idle channel")

  // a start request never reports toggles
  `MCBT_ASSERT(a_start_no_toggle, valid_o && ($past(operation_i, 2) == mcbt_pkg::OP_START) |-> (toggle_mask_o == '0), "toggle on start")

  // run flags move only with a result
  `MCBT_ASSERT(a_active_hold, !valid_o |-> $stable(active_mask_o), "active mask moved without result")

endmodule

bind multi_channel_blink_timer mcbt_checker u_mcbt_checker (.*);

`default_nettype wire
